### rtl/core/rbpa_pkg.sv
// Shared types and constants for the region bump page allocator.
// Used by every module of the block; depends on nothing else.
package rbpa_pkg;

    localparam int ADDR_W      = 64;
    localparam int PAGES_W     = 52;
    localparam int MAX_REGIONS = 64;
    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);

    // Region count needs to hold MAX_REGIONS itself; a table index does not.
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    localparam logic [ADDR_W-1:0] PREF_LOW_RESET = ADDR_W'(64'h0000_0000_0100_0000);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIRTUAL_OFFSET = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PREFERRED_LOW  = CFG_IDX_W'(1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_STORE  = 2'd0,
        CMD_REJECT = 2'd1,
        CMD_ALLOC  = 2'd2
    } cmd_op_t;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        cmd_op_t              op;
        logic                 close;
        logic [IDX_W-1:0]     index;
        logic [ADDR_W-1:0]    base;
        logic [PAGES_W-1:0]   pages;
        logic                 usable;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [PAGES_W-1:0] pages;
        logic               usable;
    } entry_t;

endpackage

### rtl/core/rbpa_front.sv
// Front end: accepts items, tracks the map fill state and classifies items.
// Depends on rbpa_pkg; feeds rbpa_cmd_fifo.
module rbpa_front
    import rbpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [ADDR_W-1:0]  region_base,
    input  logic [PAGES_W-1:0] region_pages,
    input  logic               region_usable,
    input  logic               last_region,
    input  logic [PAGES_W-1:0] alloc_pages,
    input  logic               q_full,
    output logic               q_push,
    output cmd_t               q_cmd,
    output logic [CNT_W-1:0]   region_count
);

    logic [CNT_W-1:0] region_count_reg;
    logic [CNT_W-1:0] region_count_next;
    logic             map_complete_reg;
    logic             map_complete_next;

    assign in_ready     = !q_full;
    assign q_push       = in_valid && !q_full;
    assign region_count = region_count_reg;

    always_comb
    begin
        region_count_next = region_count_reg;
        map_complete_next = map_complete_reg;
        q_cmd.op     = CMD_REJECT;
        q_cmd.close  = 1'b0;
        q_cmd.index  = region_count_reg[IDX_W-1:0];
        q_cmd.base   = region_base;
        q_cmd.pages  = region_pages;
        q_cmd.usable = region_usable;
        if (kind)
        begin
            q_cmd.pages = alloc_pages;
            if (map_complete_reg)
            begin
                q_cmd.op = CMD_ALLOC;
            end
        end
        else if (!map_complete_reg)
        begin
            // A full table drops the entry, but a last mark still closes the map.
            if (region_count_reg < CNT_W'(MAX_REGIONS))
            begin
                q_cmd.op          = CMD_STORE;
                region_count_next = region_count_reg + CNT_W'(1);
            end
            q_cmd.close       = last_region;
            map_complete_next = last_region;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_count_reg <= '0;
            map_complete_reg <= 1'b0;
        end
        else if (q_push)
        begin
            region_count_reg <= region_count_next;
            map_complete_reg <= map_complete_next;
        end
    end

endmodule

### rtl/core/rbpa_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on rbpa_pkg for the command type and the queue depth.
module rbpa_cmd_fifo
    import rbpa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

### rtl/core/rbpa_back.sv
// Back end: region table memory, start selection and allocation sequencer,
// and the result register. Depends on rbpa_pkg; fed by rbpa_cmd_fifo.
module rbpa_back
    import rbpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  cmd_t               q_cmd,
    output logic               q_pop,
    input  logic [CNT_W-1:0]   region_count,
    input  logic [ADDR_W-1:0]  virtual_offset,
    input  logic [ADDR_W-1:0]  preferred_low_address,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               ok,
    output logic [ADDR_W-1:0]  phys_address,
    output logic [ADDR_W-1:0]  virt_address
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EVAL,
        ST_DONE
    } state_t;

    localparam int PAD_W = ADDR_W - PAGES_W;

    entry_t table_mem [MAX_REGIONS];
    entry_t rd_entry_reg;
    logic   mem_we;

    state_t             state_reg;
    logic               sel_mode_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   cur_reg;
    logic [PAGES_W-1:0] used_reg;
    logic [CNT_W-1:0]   first_reg;
    logic               first_found_reg;
    logic [PAGES_W-1:0] req_reg;
    logic               ok_reg;
    logic               addr_valid_reg;
    logic [ADDR_W-1:0]  phys_reg;
    logic               out_valid_reg;
    logic               out_ok_reg;
    logic [ADDR_W-1:0]  out_phys_reg;
    logic [ADDR_W-1:0]  out_virt_reg;

    logic [ADDR_W-1:0]  low_gap;
    logic [ADDR_W-1:0]  gap_pages;
    logic               above;
    logic [PAGES_W-1:0] skip_pages;
    logic [PAGES_W:0]   need;
    logic               fits;
    logic               fills;
    logic [ADDR_W-1:0]  alloc_phys;
    logic [CNT_W-1:0]   idx_inc;

    assign q_pop  = (state_reg == ST_IDLE) && q_valid;
    assign mem_we = q_pop && (q_cmd.op == CMD_STORE);

    assign out_valid    = out_valid_reg;
    assign ok           = out_ok_reg;
    assign phys_address = out_phys_reg;
    assign virt_address = out_virt_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[q_cmd.index] <= '{base: q_cmd.base, pages: q_cmd.pages,
                                        usable: q_cmd.usable};
        end
        rd_entry_reg <= table_mem[idx_reg[IDX_W-1:0]];
    end

    // Start selection: a region counts when it ends above the preferred address.
    assign low_gap    = preferred_low_address - rd_entry_reg.base;
    assign gap_pages  = low_gap >> PAGE_SHIFT;
    assign above      = (rd_entry_reg.base > preferred_low_address) ||
                        ({{PAD_W{1'b0}}, rd_entry_reg.pages} > gap_pages);
    assign skip_pages = (rd_entry_reg.base < preferred_low_address) ?
                        gap_pages[PAGES_W-1:0] : '0;

    // Allocation within the entry under the index.
    assign need       = {1'b0, used_reg} + {1'b0, req_reg};
    assign fits       = {1'b0, rd_entry_reg.pages} >= need;
    assign fills      = need >= {1'b0, rd_entry_reg.pages};
    assign alloc_phys = rd_entry_reg.base + ({{PAD_W{1'b0}}, used_reg} << PAGE_SHIFT);
    assign idx_inc    = idx_reg + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            sel_mode_reg    <= 1'b0;
            idx_reg         <= '0;
            cur_reg         <= '0;
            used_reg        <= '0;
            first_reg       <= '0;
            first_found_reg <= 1'b0;
            req_reg         <= '0;
            ok_reg          <= 1'b0;
            addr_valid_reg  <= 1'b0;
            phys_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_ok_reg      <= 1'b0;
            out_phys_reg    <= '0;
            out_virt_reg    <= '0;
        end
        else
        begin
            // In ST_DONE the result register is reloaded below instead.
            if (out_valid_reg && out_ready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        phys_reg        <= '0;
                        addr_valid_reg  <= 1'b0;
                        req_reg         <= q_cmd.pages;
                        first_reg       <= region_count;
                        first_found_reg <= 1'b0;
                        ok_reg          <= (q_cmd.op == CMD_STORE);
                        unique case (q_cmd.op)
                            CMD_ALLOC:
                            begin
                                sel_mode_reg <= 1'b0;
                                idx_reg      <= cur_reg;
                                state_reg    <= ST_CHECK;
                            end
                            CMD_STORE, CMD_REJECT:
                            begin
                                sel_mode_reg <= 1'b1;
                                idx_reg      <= '0;
                                state_reg    <= q_cmd.close ? ST_CHECK : ST_DONE;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_CHECK:
                begin
                    if (idx_reg >= region_count)
                    begin
                        // Scan ran off the table: fall back or leave exhausted.
                        cur_reg   <= sel_mode_reg ? first_reg : region_count;
                        used_reg  <= '0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    if (!rd_entry_reg.usable)
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= ST_CHECK;
                    end
                    else if (sel_mode_reg)
                    begin
                        if (!first_found_reg)
                        begin
                            first_reg       <= idx_reg;
                            first_found_reg <= 1'b1;
                        end
                        if (above)
                        begin
                            cur_reg   <= idx_reg;
                            used_reg  <= skip_pages;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            idx_reg   <= idx_inc;
                            state_reg <= ST_CHECK;
                        end
                    end
                    else if (fits)
                    begin
                        phys_reg       <= alloc_phys;
                        addr_valid_reg <= 1'b1;
                        ok_reg         <= 1'b1;
                        state_reg      <= ST_DONE;
                        // A region filled up moves on; unusable ones are skipped later.
                        if (fills)
                        begin
                            cur_reg  <= idx_inc;
                            used_reg <= '0;
                        end
                        else
                        begin
                            cur_reg  <= idx_reg;
                            used_reg <= need[PAGES_W-1:0];
                        end
                    end
                    else
                    begin
                        used_reg  <= '0;
                        idx_reg   <= idx_inc;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_ok_reg    <= ok_reg;
                        out_phys_reg  <= phys_reg;
                        out_virt_reg  <= addr_valid_reg ? phys_reg + virtual_offset : '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/region_bump_page_allocator_core.sv
// Top level of the region bump page allocator: configuration registers and
// the front end, command queue and back end. Depends on rbpa_pkg, rbpa_front,
// rbpa_cmd_fifo and rbpa_back.

// The block takes memory-map regions (kind 0) into a 64-entry table and then
// hands out contiguous page runs (kind 1) by bump allocation, one result item
// per input item. The front end accepts an item whenever its two-entry command
// queue has room, even while a result waits at the output, and classifies it
// against the map state. The back end works through one command at a time
// against the region table, a memory with a registered read port, so each
// table entry it visits passes a check state and then an evaluation state.
// The load marked last runs the start selection over the table. An allocation
// visits entries from the current region on until one fits or the scan runs
// off the table. The table needs no clearing after reset.
// Configuration writes are always accepted and take effect at once; they
// should only happen while no item is in flight.
module region_bump_page_allocator_core
    import rbpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [ADDR_W-1:0]    region_base,
    input  logic [PAGES_W-1:0]   region_pages,
    input  logic                 region_usable,
    input  logic                 last_region,
    input  logic [PAGES_W-1:0]   alloc_pages,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 ok,
    output logic [ADDR_W-1:0]    phys_address,
    output logic [ADDR_W-1:0]    virt_address
);

    logic [ADDR_W-1:0] virtual_offset_reg;
    logic [ADDR_W-1:0] preferred_low_reg;

    logic             q_push;
    cmd_t             q_push_cmd;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    cmd_t             q_pop_cmd;
    logic [CNT_W-1:0] region_count;

    // The register port never stalls. Writes to unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            virtual_offset_reg <= '0;
            preferred_low_reg  <= PREF_LOW_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_VIRTUAL_OFFSET: virtual_offset_reg <= cfg_data;
                CFG_PREFERRED_LOW:  preferred_low_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The front end owns the region count and the map-complete flag, since
    // both follow from the order of accepted loads alone.
    rbpa_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .region_base   (region_base),
        .region_pages  (region_pages),
        .region_usable (region_usable),
        .last_region   (last_region),
        .alloc_pages   (alloc_pages),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_push_cmd),
        .region_count  (region_count)
    );

    rbpa_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_pop_cmd)
    );

    // The back end holds the table, the current region and pages used, and
    // the output register that parts it from the downstream side.
    rbpa_back u_back (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .q_valid               (q_valid),
        .q_cmd                 (q_pop_cmd),
        .q_pop                 (q_pop),
        .region_count          (region_count),
        .virtual_offset        (virtual_offset_reg),
        .preferred_low_address (preferred_low_reg),
        .out_valid             (out_valid),
        .out_ready             (out_ready),
        .ok                    (ok),
        .phys_address          (phys_address),
        .virt_address          (virt_address)
    );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for region_bump_page_allocator_core: region map loads,
// start selection, bump page allocation and both address registers.
// Depends on rbpa_pkg and the RTL of the block; it reads no files.

module testbench;
    import rbpa_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 7;
    // The longest legal quiet stretch is the long receiver hold plus one full
    // table scan, so this limit leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 250;
    localparam int SETTLE_CYCLES  = 2 * MAX_REGIONS + 20;
    localparam int MAX_PRINTED    = 100;

    // Codes of the kind field.
    localparam bit KIND_LOAD  = 1'b0;
    localparam bit KIND_ALLOC = 1'b1;

    // Regions below this index are small, so plain requests walk through them
    // region by region; from here on the regions are huge.
    localparam int SMALL_ZONE_END = 36;
    localparam int BIG_REQUEST_CAP = 10;

    localparam bit [PAGES_W-1:0] PAGES_MAX  = '1;
    localparam bit [ADDR_W-1:0]  ADDR_MAX   = '1;
    // Not page aligned on purpose: the start clip must round down.
    localparam bit [ADDR_W-1:0]  START_PREF = 64'h0000_0000_0100_0123;

    typedef struct packed {
        bit                 kind;
        bit [ADDR_W-1:0]    base;
        bit [PAGES_W-1:0]   pages;
        bit                 usable;
        bit                 last;
        bit [PAGES_W-1:0]   want;
    } alloc_item_t;

    typedef struct packed {
        bit                ok;
        bit [ADDR_W-1:0]   phys;
        bit [ADDR_W-1:0]   virt;
    } grant_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 kind;
    logic [ADDR_W-1:0]    region_base;
    logic [PAGES_W-1:0]   region_pages;
    logic                 region_usable;
    logic                 last_region;
    logic [PAGES_W-1:0]   alloc_pages;
    logic                 out_valid;
    logic                 out_ready;
    logic                 ok;
    logic [ADDR_W-1:0]    phys_address;
    logic [ADDR_W-1:0]    virt_address;

    region_bump_page_allocator_core dut (.*);

    // Our own copy of the allocator state, advanced once per accepted item.
    bit [ADDR_W-1:0]  map_base   [MAX_REGIONS];
    bit [PAGES_W-1:0] map_pages  [MAX_REGIONS];
    bit               map_usable [MAX_REGIONS];
    int unsigned      map_count  = 0;
    bit               map_closed = 1'b0;
    int unsigned      cur_region = 0;
    bit [PAGES_W-1:0] used_pages = '0;
    bit [ADDR_W-1:0]  offset_reg = '0;
    bit [ADDR_W-1:0]  pref_reg   = PREF_LOW_RESET;

    // Grants predicted at acceptance, oldest first.
    grant_t pending_grants[$];

    int fail_count      = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int loads_sent      = 0;
    int requests_sent   = 0;
    int grants_ok       = 0;
    int reg_writes      = 0;
    int big_requests    = 0;
    int quiet_cycles    = 0;

    // Idling controls shared by the sender and the receiver process.
    bit in_gaps    = 1'b0;
    bit out_gaps   = 1'b0;
    int hold_left  = 0;
    int stall_left = 0;

    always begin
        clk = 1'b0;
        #(CLK_PERIOD / 2);
        clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    function automatic bit [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bit [PAGES_W-1:0] rand52();
        return PAGES_W'({$urandom, $urandom});
    endfunction

    // Fields that an item of the other kind ignores carry random noise.
    function automatic alloc_item_t make_load(input bit [ADDR_W-1:0] base,
                                              input bit [PAGES_W-1:0] pages,
                                              input bit usable, input bit last);
        alloc_item_t it;
        it.kind   = KIND_LOAD;
        it.base   = base;
        it.pages  = pages;
        it.usable = usable;
        it.last   = last;
        it.want   = rand52();
        return it;
    endfunction

    function automatic alloc_item_t make_alloc(input bit [PAGES_W-1:0] want);
        alloc_item_t it;
        it.kind   = KIND_ALLOC;
        it.base   = rand64();
        it.pages  = rand52();
        it.usable = 1'($urandom_range(0, 1));
        it.last   = 1'($urandom_range(0, 1));
        it.want   = want;
        return it;
    endfunction

    // Start selection when the map closes: the first usable region that ends
    // above the preferred address, clipped up to it by whole pages, else the
    // first usable region, else nothing (current region equals the count).
    function automatic void pick_start();
        int unsigned fallback;
        bit [ADDR_W-1:0] gap_pages;
        fallback = map_count;
        for (int unsigned i = 0; i < map_count; i++) begin
            if (!map_usable[i])
                continue;
            if (fallback == map_count)
                fallback = i;
            gap_pages = (pref_reg - map_base[i]) / PAGE_BYTES;
            if (map_base[i] > pref_reg || ADDR_W'(map_pages[i]) > gap_pages) begin
                cur_region = i;
                used_pages = (map_base[i] < pref_reg) ? PAGES_W'(gap_pages) : '0;
                return;
            end
        end
        cur_region = fallback;
        used_pages = '0;
    endfunction

    // Bump allocation from the current region on. A usable region that is too
    // small for the request is abandoned; a region that becomes full moves the
    // pointer on to the next usable one.
    function automatic bit take_pages(input bit [PAGES_W-1:0] want,
                                      output bit [ADDR_W-1:0] addr);
        bit [PAGES_W:0] need;
        addr = '0;
        while (cur_region < map_count) begin
            if (map_usable[cur_region]) begin
                need = {1'b0, used_pages} + {1'b0, want};
                if ({1'b0, map_pages[cur_region]} >= need) begin
                    addr = map_base[cur_region] + ADDR_W'(used_pages) * PAGE_BYTES;
                    used_pages = need[PAGES_W-1:0];
                    if (used_pages >= map_pages[cur_region]) begin
                        cur_region++;
                        used_pages = '0;
                        while (cur_region < map_count && !map_usable[cur_region])
                            cur_region++;
                    end
                    return 1'b1;
                end
                used_pages = '0;
            end
            cur_region++;
        end
        return 1'b0;
    endfunction

    function automatic grant_t compute_grant(input alloc_item_t it);
        grant_t g;
        bit [ADDR_W-1:0] addr;
        g = '0;
        if (it.kind == KIND_LOAD) begin
            // Loads are ignored once the map is closed; a full table drops the
            // entry but a last mark still closes the map.
            if (!map_closed) begin
                if (map_count < MAX_REGIONS) begin
                    map_base[map_count]   = it.base;
                    map_pages[map_count]  = it.pages;
                    map_usable[map_count] = it.usable;
                    map_count++;
                    g.ok = 1'b1;
                end
                if (it.last) begin
                    map_closed = 1'b1;
                    pick_start();
                end
            end
        end else if (map_closed) begin
            if (take_pages(it.want, addr)) begin
                g.ok   = 1'b1;
                g.phys = addr;
                g.virt = addr + offset_reg;
            end
        end
        return g;
    endfunction

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        // Printing is capped so that a badly broken block cannot flood the
        // log; every mismatch is still counted.
        if (fail_count < MAX_PRINTED)
            $display("MISMATCH %s: got %h, expected %h (result %0d, t=%0t)",
                     what, got, want, results_checked, $realtime);
        fail_count++;
    endtask

    // Sends one item and waits for it to be accepted. Valid is left high so
    // that a following call can present its item in the very next cycle;
    // stop_items lowers it when the stream pauses.
    task automatic send_item(input alloc_item_t it, output bit granted);
        grant_t g;
        if (in_gaps && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= it.kind;
        region_base   <= it.base;
        region_pages  <= it.pages;
        region_usable <= it.usable;
        last_region   <= it.last;
        alloc_pages   <= it.want;
        do
            @(posedge clk);
        while (!in_ready);
        g = compute_grant(it);
        pending_grants.push_back(g);
        granted = g.ok;
        items_sent++;
        if (it.kind == KIND_LOAD)
            loads_sent++;
        else
            requests_sent++;
        if (g.ok)
            grants_ok++;
    endtask

    task automatic stop_items();
        in_valid <= 1'b0;
    endtask

    // The sender pauses here until every predicted grant has been checked.
    // Every item yields exactly one result, so the block is idle afterwards.
    task automatic wait_all_grants();
        stop_items();
        while (pending_grants.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_VIRTUAL_OFFSET)
            offset_reg = value;
        else if (idx == CFG_PREFERRED_LOW)
            pref_reg = value;
        reg_writes++;
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
    endtask

    // Both registers at their extremes right after reset, then the preferred
    // address that the map below is built around. The offset stays at its
    // maximum, so early virtual addresses wrap.
    task automatic test_register_extremes();
        write_reg(CFG_VIRTUAL_OFFSET, ADDR_MAX);
        write_reg(CFG_PREFERRED_LOW, '0);
        write_reg(CFG_PREFERRED_LOW, ADDR_MAX);
        write_reg(CFG_PREFERRED_LOW, START_PREF);
        end_writes();
    endtask

    // Requests before the map is closed must fail without touching state.
    task automatic test_request_before_map();
        bit granted;
        send_item(make_alloc(PAGES_W'(1)), granted);
        send_item(make_alloc(PAGES_MAX), granted);
        send_item(make_alloc(PAGES_W'(0)), granted);
    endtask

    // Fills the table. The first regions are fixed so that start selection
    // skips a usable region that ends below the preferred address and an
    // unusable one, then clips into the third. The map is closed by a last
    // mark on a load that arrives with the table already full.
    task automatic test_map_load();
        bit granted;
        bit [PAGES_W-1:0] pages;
        send_item(make_load(64'h0, PAGES_W'(16), 1'b1, 1'b0), granted);
        send_item(make_load(64'h0010_0000, 52'h2000, 1'b0, 1'b0), granted);
        send_item(make_load(64'h0080_0000, 52'h802, 1'b1, 1'b0), granted);
        send_item(make_load(rand64(), rand52(), 1'b0, 1'b0), granted);
        // A usable region of zero pages.
        send_item(make_load(rand64(), PAGES_W'(0), 1'b1, 1'b0), granted);
        // Region at the top of the address space, so handed-out addresses wrap.
        send_item(make_load(64'hFFFF_FFFF_FFFF_E000, PAGES_W'(4), 1'b1, 1'b0), granted);
        // Base that is not page aligned.
        send_item(make_load(64'h0000_1234_5678_9ABC, PAGES_W'(3), 1'b1, 1'b0), granted);
        send_item(make_load(rand64(), PAGES_W'(0), 1'b1, 1'b0), granted);
        send_item(make_load(rand64(), PAGES_W'(1), 1'b1, 1'b0), granted);
        for (int i = 9; i < SMALL_ZONE_END; i++)
            send_item(make_load(rand64(), PAGES_W'($urandom_range(0, 8)),
                                $urandom_range(0, 3) != 0, 1'b0), granted);
        for (int i = SMALL_ZONE_END; i < MAX_REGIONS; i++) begin
            pages = (i % 2 == 0) ? PAGES_MAX : (rand52() | (52'h1 << (PAGES_W - 1)));
            send_item(make_load(rand64(), pages, i % 7 != 0, 1'b0), granted);
        end
        // Table full: these are dropped and answer not ok.
        repeat (6)
            send_item(make_load(rand64(), rand52(), 1'($urandom_range(0, 1)), 1'b0),
                      granted);
        send_item(make_load(rand64(), rand52(), 1'($urandom_range(0, 1)), 1'b1), granted);
    endtask

    // Loads after the map has closed are ignored, last mark or not.
    task automatic test_load_after_close();
        bit granted;
        send_item(make_load(rand64(), rand52(), 1'b1, 1'b1), granted);
        send_item(make_load(rand64(), rand52(), 1'b0, 1'b0), granted);
    endtask

    // Walks the fixed regions: zero-page requests, a request that does not
    // fit the clipped start region, skips over an unusable and an empty
    // region, an address wrap, an exact fill, and a zero-page request on an
    // empty usable region, which answers its base and moves on.
    task automatic test_directed_alloc();
        bit granted;
        send_item(make_alloc(PAGES_W'(0)), granted);
        send_item(make_alloc(PAGES_W'(1)), granted);
        send_item(make_alloc(PAGES_W'(2)), granted);
        send_item(make_alloc(PAGES_W'(2)), granted);
        send_item(make_alloc(PAGES_W'(0)), granted);
        send_item(make_alloc(PAGES_W'(3)), granted);
        send_item(make_alloc(PAGES_W'(0)), granted);
        send_item(make_alloc(PAGES_W'(1)), granted);
    endtask

    // Mostly short requests with random sizes, some zero-page requests, a
    // little noise from late loads, and, once the huge regions are reached,
    // occasional requests of random 52-bit size. Those are held back while
    // few regions remain, so the allocator stays alive until the end.
    task automatic test_random_traffic(input int count, input bit gaps,
                                       input bit [ADDR_W-1:0] offset);
        alloc_item_t it;
        bit granted;
        wait_all_grants();
        write_reg(CFG_VIRTUAL_OFFSET, offset);
        write_reg(CFG_PREFERRED_LOW, rand64());
        end_writes();
        in_gaps  = gaps;
        out_gaps = gaps;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 19) == 0) begin
                it = make_load(rand64(), rand52(), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
            end else if (cur_region >= SMALL_ZONE_END && cur_region + 6 < map_count
                         && big_requests < BIG_REQUEST_CAP && $urandom_range(0, 7) == 0) begin
                it = make_alloc(rand52());
                big_requests++;
            end else if ($urandom_range(0, 11) == 0) begin
                it = make_alloc(PAGES_W'(0));
            end else begin
                it = make_alloc(PAGES_W'($urandom_range(1, 8)));
            end
            send_item(it, granted);
            // Idling switches on and off in stretches.
            if (gaps && k % 50 == 49) begin
                in_gaps  = 1'($urandom_range(0, 1));
                out_gaps = 1'($urandom_range(0, 1));
            end
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering items back to back, so the command queue fills and the input
    // stalls. Then the sender waits until every grant is back.
    task automatic test_backpressure();
        bit granted;
        in_gaps   = 1'b0;
        hold_left = HOLD_CYCLES;
        repeat (24)
            send_item(make_alloc(PAGES_W'($urandom_range(1, 4))), granted);
        wait_all_grants();
    endtask

    // Requests of the largest size each use up one huge region until none
    // fits; from then on the allocator is exhausted and answers not ok.
    task automatic test_exhaustion();
        bit granted;
        int guard;
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
        granted  = 1'b1;
        guard    = 0;
        while (granted && guard < 2 * MAX_REGIONS) begin
            send_item(make_alloc(PAGES_MAX), granted);
            guard++;
        end
        send_item(make_alloc(PAGES_W'(1)), granted);
        send_item(make_alloc(PAGES_W'(0)), granted);
        send_item(make_alloc(PAGES_W'(8)), granted);
        wait_all_grants();
    endtask

    // Receiver: random stalls while idling is on, plus the long hold that
    // test_backpressure requests.
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (out_gaps && $urandom_range(0, 7) == 0) begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(1, 17) - 1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Every accepted result is compared field by field with the oldest
    // predicted grant.
    always @(posedge clk) begin
        grant_t want_g;
        if (rst_n && out_valid && out_ready) begin
            results_checked++;
            if (pending_grants.size() == 0) begin
                report_mismatch("result with no item outstanding", phys_address, '0);
            end else begin
                want_g = pending_grants.pop_front();
                if (ok !== want_g.ok)
                    report_mismatch("ok", ADDR_W'(ok), ADDR_W'(want_g.ok));
                if (phys_address !== want_g.phys)
                    report_mismatch("phys_address", phys_address, want_g.phys);
                if (virt_address !== want_g.virt)
                    report_mismatch("virt_address", virt_address, want_g.virt);
            end
        end
    end

    // Watchdog: ends the run if no handshake completes for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_grants.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Test sequence. No map can be reloaded without a reset, so one map is
    // built early and the rest of the run allocates from it. A map with no
    // usable region at all would need a second reset and is not covered.
    initial begin
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        kind          <= KIND_LOAD;
        region_base   <= '0;
        region_pages  <= '0;
        region_usable <= 1'b0;
        last_region   <= 1'b0;
        alloc_pages   <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_register_extremes();
        test_request_before_map();
        test_map_load();
        test_load_after_close();
        test_directed_alloc();
        test_random_traffic(200, 1'b1, '0);
        test_backpressure();
        test_random_traffic(180, 1'b1, rand64());
        // Last part of the run: no idling on either side.
        test_random_traffic(60, 1'b0, rand64());
        test_exhaustion();

        wait_all_grants();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d items: %0d region loads and %0d page requests, %0d granted.",
                 items_sent, loads_sent, requests_sent, grants_ok);
        $display("Compared %0d results over %0d register writes; %0d requests of 52-bit size.",
                 results_checked, reg_writes, big_requests);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/core/rbpa_pkg.sv
rtl/core/rbpa_front.sv
rtl/core/rbpa_cmd_fifo.sv
rtl/core/rbpa_back.sv
rtl/core/region_bump_page_allocator_core.sv
tb/sv/testbench.sv
